// ===== hw/rtl/obbsat_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and index codes for the oriented box overlap pipeline.
// No dependencies; imported by obbsat_proj, obbsat_ext, the top level and the testbench.
package obbsat_pkg;

    localparam int NUM_AXES = 4;
    localparam int NUM_DOTS = 2;
    localparam int NUM_EXTS = 4;

    // separating axis candidates: right and up axis of each box
    typedef enum logic [1:0] {
        AX_RA,
        AX_UA,
        AX_RB,
        AX_UB
    } axis_idx_t;

    // |rA.rB| and |rA.upB|
    typedef enum logic {
        DOT_C1,
        DOT_C2
    } dot_idx_t;

    typedef enum logic [1:0] {
        EX_WA,
        EX_HA,
        EX_WB,
        EX_HB
    } ext_idx_t;

endpackage

// ===== hw/rtl/obbsat_proj.sv =====
`timescale 1ns / 1ps
// Front half of the pipeline: centre offset, axis and offset dot products, magnitudes.
// Depends on obbsat_pkg.
module obbsat_proj #(
    parameter int POS_WIDTH      = 24,
    parameter int AXIS_FRAC_BITS = 14
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [POS_WIDTH-1:0] a_center_x,
    input  logic signed [POS_WIDTH-1:0] a_center_y,
    input  logic signed [POS_WIDTH-1:0] b_center_x,
    input  logic signed [POS_WIDTH-1:0] b_center_y,
    input  logic signed [AXIS_FRAC_BITS+1:0] a_right_x,
    input  logic signed [AXIS_FRAC_BITS+1:0] a_right_y,
    input  logic signed [AXIS_FRAC_BITS+1:0] b_right_x,
    input  logic signed [AXIS_FRAC_BITS+1:0] b_right_y,
    input  logic        [POS_WIDTH-1:0] a_width,
    input  logic        [POS_WIDTH-1:0] a_height,
    input  logic        [POS_WIDTH-1:0] b_width,
    input  logic        [POS_WIDTH-1:0] b_height,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2*(AXIS_FRAC_BITS+2)-1:0] dot_mag [obbsat_pkg::NUM_DOTS],
    output logic [POS_WIDTH+AXIS_FRAC_BITS+3:0] twice_proj [obbsat_pkg::NUM_AXES],
    output logic [POS_WIDTH-1:0] ext [obbsat_pkg::NUM_EXTS]
);
    import obbsat_pkg::*;

    localparam int AW  = AXIS_FRAC_BITS + 2;
    localparam int DW  = POS_WIDTH + 1;
    localparam int PPW = DW + AW;
    localparam int PSW = PPW + 1;
    localparam int CPW = 2 * AW;
    localparam int CSW = CPW + 1;

    function automatic logic [PSW-2:0] mag_proj(input logic signed [PSW-1:0] v);
        logic [PSW-1:0] t;
        t = v[PSW-1] ? -v : v;
        return t[PSW-2:0];
    endfunction

    function automatic logic [CSW-2:0] mag_dot(input logic signed [CSW-1:0] v);
        logic [CSW-1:0] t;
        t = v[CSW-1] ? -v : v;
        return t[CSW-2:0];
    endfunction

    // stage 1: offset
    logic                 v1_reg, v2_reg, v3_reg;
    logic                 rdy1, rdy2, rdy3;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic signed [AW-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [POS_WIDTH-1:0] ext1_reg [NUM_EXTS];

    // stage 2: products
    logic signed [CPW-1:0] axbx_reg, ayby_reg, axby_reg, aybx_reg;
    logic signed [PPW-1:0] dxax_reg, dyay_reg, dyax_reg, dxay_reg;
    logic signed [PPW-1:0] dxbx_reg, dyby_reg, dybx_reg, dxby_reg;
    logic [POS_WIDTH-1:0]  ext2_reg [NUM_EXTS];

    // stage 3: sums and magnitudes
    logic [CPW-1:0]       dot_reg [NUM_DOTS];
    logic [PSW-1:0]       tp_reg [NUM_AXES];
    logic [POS_WIDTH-1:0] ext3_reg [NUM_EXTS];

    logic signed [PSW-1:0] s_ra, s_ua, s_rb, s_ub;
    logic signed [CSW-1:0] s_c1, s_c2;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign s_ra = {dxax_reg[PPW-1], dxax_reg} + {dyay_reg[PPW-1], dyay_reg};
    assign s_ua = {dyax_reg[PPW-1], dyax_reg} - {dxay_reg[PPW-1], dxay_reg};
    assign s_rb = {dxbx_reg[PPW-1], dxbx_reg} + {dyby_reg[PPW-1], dyby_reg};
    assign s_ub = {dybx_reg[PPW-1], dybx_reg} - {dxby_reg[PPW-1], dxby_reg};
    assign s_c1 = {axbx_reg[CPW-1], axbx_reg} + {ayby_reg[CPW-1], ayby_reg};
    assign s_c2 = {axby_reg[CPW-1], axby_reg} - {aybx_reg[CPW-1], aybx_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            dx_reg <= {b_center_x[POS_WIDTH-1], b_center_x}
                    - {a_center_x[POS_WIDTH-1], a_center_x};
            dy_reg <= {b_center_y[POS_WIDTH-1], b_center_y}
                    - {a_center_y[POS_WIDTH-1], a_center_y};
            ax_reg <= a_right_x;
            ay_reg <= a_right_y;
            bx_reg <= b_right_x;
            by_reg <= b_right_y;
            ext1_reg[EX_WA] <= a_width;
            ext1_reg[EX_HA] <= a_height;
            ext1_reg[EX_WB] <= b_width;
            ext1_reg[EX_HB] <= b_height;
        end
        if (rdy2) begin
            axbx_reg <= ax_reg * bx_reg;
            ayby_reg <= ay_reg * by_reg;
            axby_reg <= ax_reg * by_reg;
            aybx_reg <= ay_reg * bx_reg;
            dxax_reg <= dx_reg * ax_reg;
            dyay_reg <= dy_reg * ay_reg;
            dyax_reg <= dy_reg * ax_reg;
            dxay_reg <= dx_reg * ay_reg;
            dxbx_reg <= dx_reg * bx_reg;
            dyby_reg <= dy_reg * by_reg;
            dybx_reg <= dy_reg * bx_reg;
            dxby_reg <= dx_reg * by_reg;
            ext2_reg <= ext1_reg;
        end
        if (rdy3) begin
            dot_reg[DOT_C1] <= mag_dot(s_c1);
            dot_reg[DOT_C2] <= mag_dot(s_c2);
            tp_reg[AX_RA]   <= {mag_proj(s_ra), 1'b0};
            tp_reg[AX_UA]   <= {mag_proj(s_ua), 1'b0};
            tp_reg[AX_RB]   <= {mag_proj(s_rb), 1'b0};
            tp_reg[AX_UB]   <= {mag_proj(s_ub), 1'b0};
            ext3_reg        <= ext2_reg;
        end
    end

    assign out_valid  = v3_reg;
    assign dot_mag    = dot_reg;
    assign twice_proj = tp_reg;
    assign ext        = ext3_reg;

endmodule

// ===== hw/rtl/obbsat_ext.sv =====
`timescale 1ns / 1ps
// Back half of the pipeline: projected extents, per-axis sums, separation compare.
// Depends on obbsat_pkg.
module obbsat_ext #(
    parameter int POS_WIDTH      = 24,
    parameter int AXIS_FRAC_BITS = 14
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  logic [2*(AXIS_FRAC_BITS+2)-1:0] dot_mag [obbsat_pkg::NUM_DOTS],
    input  logic [POS_WIDTH+AXIS_FRAC_BITS+3:0] twice_proj [obbsat_pkg::NUM_AXES],
    input  logic [POS_WIDTH-1:0] ext [obbsat_pkg::NUM_EXTS],
    output logic out_valid,
    input  logic out_ready,
    output logic overlap
);
    import obbsat_pkg::*;

    localparam int F   = AXIS_FRAC_BITS;
    localparam int CW  = 2 * (F + 2);
    localparam int TPW = POS_WIDTH + F + 4;
    localparam int EPW = POS_WIDTH + CW;
    localparam int SW  = EPW + 2;
    localparam int QW  = SW - F;

    logic v4_reg, v5_reg, v6_reg;
    logic rdy4, rdy5, rdy6;

    logic [EPW-1:0]       p1_reg [NUM_AXES];
    logic [EPW-1:0]       p2_reg [NUM_AXES];
    logic [POS_WIDTH-1:0] own_reg [NUM_AXES];
    logic [TPW-1:0]       tp4_reg [NUM_AXES];
    logic [SW-1:0]        sum_reg [NUM_AXES];
    logic [TPW-1:0]       tp5_reg [NUM_AXES];
    logic                 overlap_reg;
    logic [NUM_AXES-1:0]  sep;

    assign rdy6     = !v6_reg || out_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign in_ready = rdy4;

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            sep[k] = {{(QW-TPW){1'b0}}, tp5_reg[k]} > sum_reg[k][SW-1:F];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (rdy4) v4_reg <= in_valid;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            p1_reg[AX_RA]  <= ext[EX_HB] * dot_mag[DOT_C2];
            p2_reg[AX_RA]  <= ext[EX_WB] * dot_mag[DOT_C1];
            p1_reg[AX_UA]  <= ext[EX_HB] * dot_mag[DOT_C1];
            p2_reg[AX_UA]  <= ext[EX_WB] * dot_mag[DOT_C2];
            p1_reg[AX_RB]  <= ext[EX_HA] * dot_mag[DOT_C2];
            p2_reg[AX_RB]  <= ext[EX_WA] * dot_mag[DOT_C1];
            p1_reg[AX_UB]  <= ext[EX_HA] * dot_mag[DOT_C1];
            p2_reg[AX_UB]  <= ext[EX_WA] * dot_mag[DOT_C2];
            own_reg[AX_RA] <= ext[EX_WA];
            own_reg[AX_UA] <= ext[EX_HA];
            own_reg[AX_RB] <= ext[EX_WB];
            own_reg[AX_UB] <= ext[EX_HB];
            tp4_reg        <= twice_proj;
        end
        if (rdy5) begin
            // own extent on its own axis counts as scaled by 2^2F
            for (int k = 0; k < NUM_AXES; k++) begin
                sum_reg[k] <= {2'b00, p1_reg[k]} + {2'b00, p2_reg[k]}
                            + {{(SW-POS_WIDTH-2*F){1'b0}}, own_reg[k], {(2*F){1'b0}}};
            end
            tp5_reg <= tp4_reg;
        end
        if (rdy6) begin
            overlap_reg <= ~|sep;
        end
    end

    assign out_valid = v6_reg;
    assign overlap   = overlap_reg;

endmodule

// ===== hw/rtl/oriented_box_overlap_test_top.sv =====
`timescale 1ns / 1ps
// Top level of the oriented box overlap test: stream ports and field packing.
// Depends on obbsat_pkg, obbsat_proj and obbsat_ext.
//
//  channel   | direction | beat contents
//  ----------+-----------+------------------------------------------------
//  s_axis_*  | in        | one box pair (two centres, right axes, extents)
//  m_axis_*  | out       | one overlap flag per box pair
//
// One box pair per cycle sustained while the output is not stalled; each beat
// passes through the six register stages (offset, products, magnitudes,
// extent products, sums, compare). Each stage holds its own valid bit, so a
// stalled output only holds the stages that are full; bubbles still close up.
// aresetn is synchronous and clears the valid bits only.
module oriented_box_overlap_test_top #(
    parameter int POS_WIDTH      = 24,
    parameter int AXIS_FRAC_BITS = 14
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // a_center_x, a_center_y, b_center_x, b_center_y, a_right_x, a_right_y,
    // b_right_x, b_right_y, a_width, a_height, b_width, b_height, zero pad
    input  logic [((8*POS_WIDTH+4*(AXIS_FRAC_BITS+2)+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // overlap, zero pad
    output logic [7:0] m_axis_tdata
);
    import obbsat_pkg::*;

    localparam int P  = POS_WIDTH;
    localparam int AW = AXIS_FRAC_BITS + 2;

    localparam int OFF_ACX = 0;
    localparam int OFF_ACY = P;
    localparam int OFF_BCX = 2 * P;
    localparam int OFF_BCY = 3 * P;
    localparam int OFF_ARX = 4 * P;
    localparam int OFF_ARY = 4 * P + AW;
    localparam int OFF_BRX = 4 * P + 2 * AW;
    localparam int OFF_BRY = 4 * P + 3 * AW;
    localparam int OFF_AW  = 4 * P + 4 * AW;
    localparam int OFF_AH  = 5 * P + 4 * AW;
    localparam int OFF_BW  = 6 * P + 4 * AW;
    localparam int OFF_BH  = 7 * P + 4 * AW;

    logic                 mid_valid, mid_ready;
    logic [2*AW-1:0]      dot_mag [NUM_DOTS];
    logic [P+AW+1:0]      twice_proj [NUM_AXES];
    logic [P-1:0]         ext [NUM_EXTS];
    logic                 overlap;

    obbsat_proj #(
        .POS_WIDTH      (POS_WIDTH),
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
    ) u_proj (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .a_center_x (s_axis_tdata[OFF_ACX +: P]),
        .a_center_y (s_axis_tdata[OFF_ACY +: P]),
        .b_center_x (s_axis_tdata[OFF_BCX +: P]),
        .b_center_y (s_axis_tdata[OFF_BCY +: P]),
        .a_right_x  (s_axis_tdata[OFF_ARX +: AW]),
        .a_right_y  (s_axis_tdata[OFF_ARY +: AW]),
        .b_right_x  (s_axis_tdata[OFF_BRX +: AW]),
        .b_right_y  (s_axis_tdata[OFF_BRY +: AW]),
        .a_width    (s_axis_tdata[OFF_AW +: P]),
        .a_height   (s_axis_tdata[OFF_AH +: P]),
        .b_width    (s_axis_tdata[OFF_BW +: P]),
        .b_height   (s_axis_tdata[OFF_BH +: P]),
        .out_valid  (mid_valid),
        .out_ready  (mid_ready),
        .dot_mag    (dot_mag),
        .twice_proj (twice_proj),
        .ext        (ext)
    );

    obbsat_ext #(
        .POS_WIDTH      (POS_WIDTH),
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
    ) u_ext (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (mid_valid),
        .in_ready   (mid_ready),
        .dot_mag    (dot_mag),
        .twice_proj (twice_proj),
        .ext        (ext),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .overlap    (overlap)
    );

    assign m_axis_tdata = {7'b0000000, overlap};

endmodule

// ===== tb/oriented_box_overlap_test_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for oriented_box_overlap_test_top. Box pairs go in over the stream
// ports; each overlap flag is checked against an exact wide-integer separating-axis predictor.
// Depends on obbsat_pkg and the oriented_box_overlap_test_top RTL.
module oriented_box_overlap_test_top_tb;
    import obbsat_pkg::*;

    localparam int POS_W       = 24;
    localparam int AXIS_FRAC   = 14;
    localparam int AXIS_W      = AXIS_FRAC + 2;
    localparam int DATA_W      = ((8*POS_W + 4*AXIS_W + 7) / 8) * 8;
    localparam int LATENCY     = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int UNIT        = 1 << AXIS_FRAC;

    typedef struct {
        logic signed [POS_W-1:0]  a_cx, a_cy, b_cx, b_cy;
        logic signed [AXIS_W-1:0] a_rx, a_ry, b_rx, b_ry;
        logic [POS_W-1:0]         a_w, a_h, b_w, b_h;
    } box_pair_t;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;

    bit expected_overlaps[$];
    int err_count          = 0;
    int pairs_sent         = 0;
    int results_seen       = 0;
    int overlaps_predicted = 0;
    int cycle_count        = 0;
    int stall_left         = 0;
    bit idling_on          = 1'b1;

    always #10 aclk = ~aclk;

    oriented_box_overlap_test_top #(
        .POS_WIDTH      (POS_W),
        .AXIS_FRAC_BITS (AXIS_FRAC)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic longint unsigned abs_val(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // 2*|d.u|*2^F > own*2^2F + w1*p1 + w2*p2, evaluated exactly
    function automatic bit axis_separates(longint unsigned twice_proj, longint unsigned own,
                                          longint unsigned w1, longint unsigned p1,
                                          longint unsigned w2, longint unsigned p2);
        logic [95:0] lhs, rhs;
        lhs = 96'(twice_proj) << AXIS_FRAC;
        rhs = (96'(own) << (2*AXIS_FRAC)) + 96'(w1) * 96'(p1) + 96'(w2) * 96'(p2);
        return lhs > rhs;
    endfunction

    function automatic bit predict_overlap(box_pair_t p);
        longint          dx, dy, ax, ay, bx, by;
        longint unsigned c_same, c_cross;
        bit              sep;
        axis_idx_t       k;
        dx = longint'(p.b_cx) - longint'(p.a_cx);
        dy = longint'(p.b_cy) - longint'(p.a_cy);
        ax = longint'(p.a_rx);
        ay = longint'(p.a_ry);
        bx = longint'(p.b_rx);
        by = longint'(p.b_ry);
        // |rA.rB| = |upA.upB|, |rA.upB| = |upA.rB|
        c_same  = abs_val(ax*bx + ay*by);
        c_cross = abs_val(ax*by - ay*bx);
        sep = 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
            k = axis_idx_t'(i);
            case (k)
                AX_RA: sep |= axis_separates(2 * abs_val(dx*ax + dy*ay), 64'(p.a_w),
                                             64'(p.b_h), c_cross, 64'(p.b_w), c_same);
                AX_UA: sep |= axis_separates(2 * abs_val(dy*ax - dx*ay), 64'(p.a_h),
                                             64'(p.b_h), c_same, 64'(p.b_w), c_cross);
                AX_RB: sep |= axis_separates(2 * abs_val(dx*bx + dy*by), 64'(p.b_w),
                                             64'(p.a_h), c_cross, 64'(p.a_w), c_same);
                AX_UB: sep |= axis_separates(2 * abs_val(dy*bx - dx*by), 64'(p.b_h),
                                             64'(p.a_h), c_same, 64'(p.a_w), c_cross);
                default: ;
            endcase
        end
        return !sep;
    endfunction

    function automatic box_pair_t make_pair(int a_cx, int a_cy, int b_cx, int b_cy,
                                            int a_rx, int a_ry, int b_rx, int b_ry,
                                            int a_w, int a_h, int b_w, int b_h);
        box_pair_t p;
        p.a_cx = POS_W'(a_cx); p.a_cy = POS_W'(a_cy);
        p.b_cx = POS_W'(b_cx); p.b_cy = POS_W'(b_cy);
        p.a_rx = AXIS_W'(a_rx); p.a_ry = AXIS_W'(a_ry);
        p.b_rx = AXIS_W'(b_rx); p.b_ry = AXIS_W'(b_ry);
        p.a_w  = POS_W'(a_w);  p.a_h  = POS_W'(a_h);
        p.b_w  = POS_W'(b_w);  p.b_h  = POS_W'(b_h);
        return p;
    endfunction

    // unit axes, sizes on a random scale, offsets around the contact distance
    function automatic box_pair_t random_oriented_pair();
        box_pair_t p;
        int        scale, span, dx, dy;
        real       ta, tb;
        scale = ($urandom_range(0, 19) == 0) ? POS_W : $urandom_range(2, 20);
        p.a_w = POS_W'($urandom_range(0, (1 << scale) - 1));
        p.a_h = POS_W'($urandom_range(0, (1 << scale) - 1));
        p.b_w = POS_W'($urandom_range(0, (1 << scale) - 1));
        p.b_h = POS_W'($urandom_range(0, (1 << scale) - 1));
        if ($urandom_range(0, 3) == 0) begin
            // shared axis-aligned frame, x offset at contact (rounded down) or one lsb past it
            p.a_rx = AXIS_W'(UNIT); p.a_ry = '0; p.b_rx = AXIS_W'(UNIT); p.b_ry = '0;
            dx = ((int'(p.a_w) + int'(p.b_w)) >> 1) + int'($urandom_range(0, 1));
            dy = $urandom_range(0, (int'(p.a_h) + int'(p.b_h)) >> 1);
            if ($urandom_range(0, 1)) dx = -dx;
            if ($urandom_range(0, 1)) dy = -dy;
        end else begin
            ta = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
            tb = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
            p.a_rx = AXIS_W'(int'(UNIT * $cos(ta)));
            p.a_ry = AXIS_W'(int'(UNIT * $sin(ta)));
            p.b_rx = AXIS_W'(int'(UNIT * $cos(tb)));
            p.b_ry = AXIS_W'(int'(UNIT * $sin(tb)));
            span = 1 << (scale + 1);
            dx = int'($urandom_range(0, 2*span)) - span;
            dy = int'($urandom_range(0, 2*span)) - span;
        end
        p.a_cx = POS_W'($urandom);
        p.a_cy = POS_W'($urandom);
        p.b_cx = POS_W'(int'(p.a_cx) + dx);
        p.b_cy = POS_W'(int'(p.a_cy) + dy);
        return p;
    endfunction

    task automatic send_box_pair(box_pair_t p);
        int r, gap;
        bit flag;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (idling_on && r >= 55)
            gap = (r < 85) ? $urandom_range(1, 3) :
                  (r < 97) ? $urandom_range(4, 10) : $urandom_range(20, 60);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.b_h, p.b_w, p.a_h, p.a_w, p.b_ry, p.b_rx, p.a_ry, p.a_rx,
                          p.b_cy, p.b_cx, p.a_cy, p.a_cx};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        flag = predict_overlap(p);
        expected_overlaps.push_back(flag);
        pairs_sent++;
        if (flag) overlaps_predicted++;
    endtask

    task automatic test_directed_cases();
        box_pair_t cases[$];
        cases.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        cases.push_back(make_pair(0, 0, 0, 0, UNIT, 0, UNIT, 0, 512, 512, 512, 512));
        // contact along x, then one lsb apart
        cases.push_back(make_pair(0, 0, 512, 0, UNIT, 0, UNIT, 0, 512, 256, 512, 256));
        cases.push_back(make_pair(0, 0, 513, 0, UNIT, 0, UNIT, 0, 512, 256, 512, 256));
        // boxes turned a quarter, contact along y
        cases.push_back(make_pair(0, 0, 0, 512, 0, UNIT, 0, UNIT, 512, 256, 512, 256));
        cases.push_back(make_pair(0, 0, 0, 513, 0, UNIT, 0, UNIT, 512, 256, 512, 256));
        cases.push_back(make_pair(100, -200, 484, -200, -UNIT, 0, 0, -UNIT, 256, 512, 256, 512));
        cases.push_back(make_pair(0, 0, 725, 725, 11585, 11585, UNIT, 0, 1024, 1024, 512, 512));
        cases.push_back(make_pair(0, 0, 1500, 700, 14189, 8192, 8192, -14189,
                                  2048, 1024, 1024, 2048));
        // zero axes never separate
        cases.push_back(make_pair(0, 0, 1000, -3000, 0, 0, 0, 0, 256, 256, 256, 256));
        // zero extents
        cases.push_back(make_pair(300, 300, 300, 300, UNIT, 0, 0, UNIT, 0, 0, 0, 0));
        cases.push_back(make_pair(300, 300, 301, 300, UNIT, 0, 0, UNIT, 0, 0, 0, 0));
        // field extremes
        cases.push_back(make_pair(-8388608, -8388608, 8388607, 8388607,
                                  UNIT, 0, UNIT, 0, 0, 0, 0, 0));
        cases.push_back(make_pair(-8388608, -8388608, 8388607, 8388607, UNIT, 0, -UNIT, 0,
                                  16777215, 16777215, 16777215, 16777215));
        cases.push_back(make_pair(0, 0, 4096, -4096, 32767, -32768, -32768, 32767,
                                  16777215, 0, 0, 16777215));
        cases.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1,
                                  16777215, 16777215, 16777215, 16777215));
        cases.push_back(make_pair(5592405, 11184810, 11184810, 5592405,
                                  21845, 43690, 43690, 21845,
                                  5592405, 11184810, 11184810, 5592405));
        foreach (cases[i]) send_box_pair(cases[i]);
    endtask

    task automatic test_oriented_pairs(int n);
        repeat (n) send_box_pair(random_oriented_pair());
    endtask

    // every field random, including axis values outside the unit range
    task automatic test_raw_field_patterns(int n);
        box_pair_t p;
        repeat (n) begin
            p.a_cx = POS_W'($urandom); p.a_cy = POS_W'($urandom);
            p.b_cx = POS_W'($urandom); p.b_cy = POS_W'($urandom);
            p.a_rx = AXIS_W'($urandom); p.a_ry = AXIS_W'($urandom);
            p.b_rx = AXIS_W'($urandom); p.b_ry = AXIS_W'($urandom);
            p.a_w  = POS_W'($urandom); p.a_h  = POS_W'($urandom);
            p.b_w  = POS_W'($urandom); p.b_h  = POS_W'($urandom);
            if ($urandom_range(0, 1)) begin
                p.b_cx = POS_W'(int'(p.a_cx) + int'($urandom & 32'hFFFF) - 32'h8000);
                p.b_cy = POS_W'(int'(p.a_cy) + int'($urandom & 32'hFFFF) - 32'h8000);
            end
            send_box_pair(p);
        end
    endtask

    task automatic test_back_to_back(int n);
        idling_on = 1'b0;
        repeat (n) send_box_pair(random_oriented_pair());
        idling_on = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (idling_on && $urandom_range(0, 99) < 30) begin
            m_axis_tready <= 1'b0;
            stall_left    <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_overlaps.size() == 0) begin
                $error("result beat with no box pair outstanding");
                err_count++;
            end else begin
                if (m_axis_tdata[0] !== expected_overlaps[0]) begin
                    $error("overlap mismatch: expected %0d, actual %0d",
                           expected_overlaps[0], m_axis_tdata[0]);
                    err_count++;
                end
                void'(expected_overlaps.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_overlaps.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_oriented_pairs(430);
        test_raw_field_patterns(120);
        test_back_to_back(130);

        s_axis_tvalid <= 1'b0;
        while (expected_overlaps.size() != 0) @(posedge aclk);
        repeat (2*LATENCY) @(posedge aclk);

        $display("Checked %0d overlap flags from %0d box pairs: contact edges, rotations,",
                 results_seen, pairs_sent);
        $display("raw bit patterns and full-rate beats; %0d overlapping, %0d separated",
                 overlaps_predicted, pairs_sent - overlaps_predicted);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
